[hdl/wstm_pkg.sv]
// Shared constants and types for the wall slice texture mapper.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package wstm_pkg;

  // Texture geometry
  localparam int unsigned TEX_W = 64;
  localparam int unsigned TEX_H = 64;

  // Field widths
  localparam int unsigned SCREEN_H_W = 10;
  localparam int unsigned DIST_W     = 16;
  localparam int unsigned FRAC_W     = 8;
  localparam int unsigned CELL_W     = 8;
  localparam int unsigned ROW_W      = 10;
  localparam int unsigned TEX_COL_W  = 6;
  localparam int unsigned TEX_ROW_W  = 6;

  localparam logic [SCREEN_H_W-1:0] SCREEN_H_RESET = SCREEN_H_W'(480);

  // Slice height: (screen_height << 8) / distance
  localparam int unsigned HEIGHT_W   = SCREEN_H_W + FRAC_W;
  localparam int unsigned HDIV_STEPS = HEIGHT_W;

  // 2*row - screen_height + height, two's complement
  localparam int unsigned SPAN_W = HEIGHT_W + 2;

  // Texel row numerator and quotient bits (quotient saturates at 2*TEX_H)
  localparam int unsigned NUM_W      = SPAN_W - 1 + $clog2(TEX_H);
  localparam int unsigned RDIV_STEPS = $clog2(2 * TEX_H);

  // Texel column product width
  localparam int unsigned COLP_W = FRAC_W + $clog2(TEX_W + 1);

  // Per-item data that rides along with the divisions
  typedef struct packed {
    logic [ROW_W-1:0]     row;
    logic                 use_fill;
    logic [CELL_W-1:0]    tex_sel;
    logic [TEX_COL_W-1:0] tex_col;
  } wstm_side_t;

  // Slice stage result handed to the texel row divider
  typedef struct packed {
    logic [NUM_W-1:0]    num;
    logic [HEIGHT_W-1:0] height;
    logic                do_div;
    logic                sat;
    logic                in_slice;
    wstm_side_t          side;
  } wstm_slice_t;

  typedef struct packed {
    logic                 in_slice;
    logic                 use_fill;
    logic [CELL_W-1:0]    tex_sel;
    logic [TEX_COL_W-1:0] tex_col;
    logic [TEX_ROW_W-1:0] tex_row;
  } wstm_result_t;

endpackage

[hdl/wstm_if.sv]
// Valid/ready channel interfaces for input items and result items.
// Depends on wstm_pkg for field widths.
`timescale 1ns / 1ps

interface wstm_item_if import wstm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [DIST_W-1:0]     perp_distance;
  logic                  side;
  logic [FRAC_W-1:0]     hit_frac_x;
  logic [FRAC_W-1:0]     hit_frac_y;
  logic                  ray_x_positive;
  logic                  ray_y_negative;
  logic [CELL_W-1:0]     wall_cell;
  logic [ROW_W-1:0]      row;

  modport source (
    output valid, perp_distance, side, hit_frac_x, hit_frac_y,
           ray_x_positive, ray_y_negative, wall_cell, row,
    input  ready
  );
  modport sink (
    input  valid, perp_distance, side, hit_frac_x, hit_frac_y,
           ray_x_positive, ray_y_negative, wall_cell, row,
    output ready
  );
endinterface

interface wstm_result_if import wstm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  in_slice;
  logic                  use_fill;
  logic [CELL_W-1:0]     tex_sel;
  logic [TEX_COL_W-1:0]  tex_col;
  logic [TEX_ROW_W-1:0]  tex_row;

  modport source (
    output valid, in_slice, use_fill, tex_sel, tex_col, tex_row,
    input  ready
  );
  modport sink (
    input  valid, in_slice, use_fill, tex_sel, tex_col, tex_row,
    output ready
  );
endinterface

[hdl/wstm_height_div.sv]
// Pipelined restoring divider for the slice height, one quotient bit per stage.
// Depends on wstm_pkg.
`timescale 1ns / 1ps

module wstm_height_div import wstm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [DIST_W-1:0]     dist_i,
  input  logic [SCREEN_H_W-1:0] screen_h_i,
  input  wstm_side_t            side_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [HEIGHT_W-1:0]   height_o,
  output wstm_side_t            side_o
);

  // Stage sources
  logic [DIST_W-1:0]   rem_src  [HDIV_STEPS];
  logic [HEIGHT_W-1:0] dq_src   [HDIV_STEPS];
  logic [DIST_W-1:0]   dvs_src  [HDIV_STEPS];
  wstm_side_t          side_src [HDIV_STEPS];
  logic [HDIV_STEPS-1:0] vld_src;

  // Stage registers
  logic [DIST_W-1:0]   rem_q  [HDIV_STEPS];
  logic [HEIGHT_W-1:0] dq_q   [HDIV_STEPS];
  logic [DIST_W-1:0]   dvs_q  [HDIV_STEPS];
  wstm_side_t          side_q [HDIV_STEPS];
  logic [HDIV_STEPS-1:0] valid_q;

  logic [DIST_W:0]     trial  [HDIV_STEPS];
  logic [DIST_W:0]     diff   [HDIV_STEPS];
  logic [HDIV_STEPS-1:0] fits;
  logic [DIST_W-1:0]   rem_d  [HDIV_STEPS];
  logic [HEIGHT_W-1:0] dq_d   [HDIV_STEPS];

  logic [HDIV_STEPS:0] rdy;

  // Dividend and quotient share one shift register per stage
  assign rem_src[0]  = '0;
  assign dq_src[0]   = {screen_h_i, {FRAC_W{1'b0}}};
  assign dvs_src[0]  = dist_i;
  assign side_src[0] = side_i;
  assign vld_src[0]  = in_valid_i;

  for (genvar s = 1; s < HDIV_STEPS; s++) begin : g_src
    assign rem_src[s]  = rem_q[s-1];
    assign dq_src[s]   = dq_q[s-1];
    assign dvs_src[s]  = dvs_q[s-1];
    assign side_src[s] = side_q[s-1];
    assign vld_src[s]  = valid_q[s-1];
  end

  // A zero divisor always fits, so the quotient comes out all ones (saturated)
  always_comb begin
    for (int s = 0; s < HDIV_STEPS; s++) begin
      trial[s] = {rem_src[s], dq_src[s][HEIGHT_W-1]};
      diff[s]  = trial[s] - {1'b0, dvs_src[s]};
      fits[s]  = trial[s] >= {1'b0, dvs_src[s]};
      rem_d[s] = fits[s] ? diff[s][DIST_W-1:0] : trial[s][DIST_W-1:0];
      dq_d[s]  = {dq_src[s][HEIGHT_W-2:0], fits[s]};
    end
  end

  // A stage loads when it is empty or its item moves on
  assign rdy[HDIV_STEPS] = out_ready_i;
  for (genvar s = 0; s < HDIV_STEPS; s++) begin : g_rdy
    assign rdy[s] = ~valid_q[s] | rdy[s+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int s = 0; s < HDIV_STEPS; s++) begin
        if (rdy[s]) begin
          valid_q[s] <= vld_src[s];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < HDIV_STEPS; s++) begin
      if (rdy[s]) begin
        rem_q[s]  <= rem_d[s];
        dq_q[s]   <= dq_d[s];
        dvs_q[s]  <= dvs_src[s];
        side_q[s] <= side_src[s];
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = valid_q[HDIV_STEPS-1];
  assign height_o    = dq_q[HDIV_STEPS-1];
  assign side_o      = side_q[HDIV_STEPS-1];

endmodule

[hdl/wstm_slice_calc.sv]
// Two-stage slice bounds, row containment and texel row numerator.
// Depends on wstm_pkg.
`timescale 1ns / 1ps

module wstm_slice_calc import wstm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [HEIGHT_W-1:0]   height_i,
  input  logic [SCREEN_H_W-1:0] screen_h_i,
  input  wstm_side_t            side_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output wstm_slice_t           slice_o
);

  localparam int unsigned EW = HEIGHT_W + 1;

  // Stage A: clipped start and end, signed span
  logic [SCREEN_H_W-1:0]        half_h;
  logic [HEIGHT_W-1:0]          half_ht;
  logic [EW-1:0]                start_full;
  logic [EW-1:0]                end_full;
  logic                         end_clip;
  logic [SCREEN_H_W-1:0]        start_d, start_q;
  logic signed [SCREEN_H_W:0]   end_d, end_q;
  logic [SPAN_W-1:0]            span_d, span_q;
  logic [HEIGHT_W-1:0]          height_q;
  wstm_side_t                   side_q;
  logic                         a_valid_q;

  // Stage B
  logic                         in_slice;
  logic                         span_pos;
  logic [SPAN_W-2:0]            span_mag;
  wstm_slice_t                  slice_d, slice_q;
  logic                         b_valid_q;

  logic                         a_rdy, b_rdy;

  assign half_h     = screen_h_i >> 1;
  assign half_ht    = height_i >> 1;
  assign start_full = EW'(half_h) - EW'(half_ht);
  assign end_full   = EW'(half_h) + EW'(half_ht);
  assign start_d    = start_full[EW-1] ? '0 : start_full[SCREEN_H_W-1:0];
  // Clip to the last row; a screen height of zero gives -1 (empty slice)
  assign end_clip   = end_full >= EW'(screen_h_i);
  assign end_d      = end_clip ? $signed({1'b0, screen_h_i} - (SCREEN_H_W+1)'(1))
                               : $signed({1'b0, end_full[SCREEN_H_W-1:0]});
  assign span_d     = (SPAN_W'(side_i.row) << 1) - SPAN_W'(screen_h_i) + SPAN_W'(height_i);

  assign in_slice = (side_q.row >= start_q) && ($signed({1'b0, side_q.row}) <= end_q);
  assign span_pos = ~span_q[SPAN_W-1] && (span_q != '0);
  assign span_mag = span_q[SPAN_W-2:0];

  always_comb begin
    slice_d.num      = NUM_W'(span_mag) * NUM_W'(TEX_H);
    slice_d.height   = height_q;
    slice_d.do_div   = in_slice && span_pos && (height_q != '0);
    // quotient reaches 2*TEX_H exactly when span >= 2*height
    slice_d.sat      = span_mag >= {height_q, 1'b0};
    slice_d.in_slice = in_slice;
    slice_d.side     = side_q;
  end

  assign b_rdy = ~b_valid_q | out_ready_i;
  assign a_rdy = ~a_valid_q | b_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_rdy) a_valid_q <= in_valid_i;
      if (b_rdy) b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy) begin
      start_q  <= start_d;
      end_q    <= end_d;
      span_q   <= span_d;
      height_q <= height_i;
      side_q   <= side_i;
    end
    if (b_rdy) begin
      slice_q <= slice_d;
    end
  end

  assign in_ready_o  = a_rdy;
  assign out_valid_o = b_valid_q;
  assign slice_o     = slice_q;

endmodule

[hdl/wstm_row_div.sv]
// Pipelined texel row divider (num / height), one quotient bit per stage,
// then a result stage that halves and clamps. Depends on wstm_pkg.
`timescale 1ns / 1ps

module wstm_row_div import wstm_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  wstm_slice_t  slice_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output wstm_result_t result_o
);

  wstm_slice_t             pl_src [RDIV_STEPS];
  logic [RDIV_STEPS-1:0]   q_src  [RDIV_STEPS];
  logic [RDIV_STEPS-1:0]   vld_src;

  wstm_slice_t             pl_q   [RDIV_STEPS];
  logic [RDIV_STEPS-1:0]   q_q    [RDIV_STEPS];
  logic [RDIV_STEPS-1:0]   valid_q;

  logic [NUM_W-1:0]        dvs    [RDIV_STEPS];
  logic [RDIV_STEPS-1:0]   fits;
  wstm_slice_t             pl_d   [RDIV_STEPS];
  logic [RDIV_STEPS-1:0]   q_d    [RDIV_STEPS];

  logic [RDIV_STEPS:0]     rdy;

  wstm_slice_t             last_pl;
  logic [RDIV_STEPS-1:0]   q_half;
  wstm_result_t            result_d, result_q;
  logic                    out_valid_q;

  assign pl_src[0]  = slice_i;
  assign q_src[0]   = '0;
  assign vld_src[0] = in_valid_i;

  for (genvar s = 1; s < RDIV_STEPS; s++) begin : g_src
    assign pl_src[s]  = pl_q[s-1];
    assign q_src[s]   = q_q[s-1];
    assign vld_src[s] = valid_q[s-1];
  end

  // Stage s tries height << (RDIV_STEPS-1-s); num field carries the remainder
  always_comb begin
    for (int s = 0; s < RDIV_STEPS; s++) begin
      dvs[s]  = NUM_W'(pl_src[s].height) << (RDIV_STEPS - 1 - s);
      fits[s] = pl_src[s].num >= dvs[s];
      pl_d[s] = pl_src[s];
      if (fits[s]) begin
        pl_d[s].num = pl_src[s].num - dvs[s];
      end
      q_d[s]  = {q_src[s][RDIV_STEPS-2:0], fits[s]};
    end
  end

  assign last_pl = pl_q[RDIV_STEPS-1];
  assign q_half  = q_q[RDIV_STEPS-1] >> 1;

  always_comb begin
    result_d.in_slice = last_pl.in_slice;
    result_d.use_fill = last_pl.side.use_fill;
    result_d.tex_sel  = last_pl.side.tex_sel;
    result_d.tex_col  = last_pl.side.tex_col;
    if (!last_pl.do_div) begin
      result_d.tex_row = '0;
    end else if (last_pl.sat) begin
      result_d.tex_row = TEX_ROW_W'(TEX_H - 1);
    end else begin
      result_d.tex_row = TEX_ROW_W'(q_half);
    end
  end

  assign rdy[RDIV_STEPS] = ~out_valid_q | out_ready_i;
  for (genvar s = 0; s < RDIV_STEPS; s++) begin : g_rdy
    assign rdy[s] = ~valid_q[s] | rdy[s+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      for (int s = 0; s < RDIV_STEPS; s++) begin
        if (rdy[s]) begin
          valid_q[s] <= vld_src[s];
        end
      end
      if (rdy[RDIV_STEPS]) begin
        out_valid_q <= valid_q[RDIV_STEPS-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < RDIV_STEPS; s++) begin
      if (rdy[s]) begin
        pl_q[s] <= pl_d[s];
        q_q[s]  <= q_d[s];
      end
    end
    if (rdy[RDIV_STEPS]) begin
      result_q <= result_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

[hdl/wall_slice_texture_mapper_top.sv]
// Stages: 1 input, 18 height divider, 2 slice, 7 texel row divider, 1 result.
// Throughput: one item per cycle unless the output stalls; each stage holds one
// item, so bubbles close up under output stalls and the input keeps accepting
// while any stage is free.
// Reset: rst_ni clears all stage valid bits and sets screen_height to 480.
`timescale 1ns / 1ps

// Top level: config register, input stage, and the divider/slice pipeline.
// Depends on wstm_pkg, wstm_if, wstm_height_div, wstm_slice_calc, wstm_row_div.
module wall_slice_texture_mapper_top import wstm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [SCREEN_H_W-1:0] cfg_wdata_i,
  wstm_item_if.sink             in_item,
  wstm_result_if.source         out_result
);

  // screen_height register; to be written only while the pipeline is empty (a rule for the user, unchecked here)
  logic [SCREEN_H_W-1:0] screen_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_h_q <= SCREEN_H_RESET;
    end else if (cfg_we_i) begin
      screen_h_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Input stage: texel column, fill flag and texture index need no division,
  // so they are settled here and ride along as side data.
  // ---------------------------------------------------------------------------
  logic [FRAC_W-1:0] frac;
  logic              mirror;
  logic [COLP_W-1:0] col_prod;
  logic [COLP_W-1:0] col_base;
  logic [COLP_W-1:0] col_sel;
  wstm_side_t        side_d, side_q;
  logic [DIST_W-1:0] dist_q;
  logic              s0_valid_q;
  logic              s0_rdy;

  // side 0 (x face) samples along y; side 1 (y face) along x
  assign frac     = in_item.side ? in_item.hit_frac_x : in_item.hit_frac_y;
  assign mirror   = in_item.side ? in_item.ray_y_negative : in_item.ray_x_positive;
  assign col_prod = COLP_W'(frac) * COLP_W'(TEX_W);
  assign col_base = col_prod >> FRAC_W;
  assign col_sel  = mirror ? (COLP_W'(TEX_W - 1) - col_base) : col_base;

  always_comb begin
    side_d.row      = in_item.row;
    side_d.use_fill = (in_item.wall_cell == '0);
    // cell 0 reports index 0 with the fill flag set
    side_d.tex_sel  = side_d.use_fill ? '0 : (in_item.wall_cell - CELL_W'(1));
    side_d.tex_col  = TEX_COL_W'(col_sel);
  end

  // ---------------------------------------------------------------------------
  // Pipeline sections
  // ---------------------------------------------------------------------------
  logic                hd_in_rdy;
  logic                hd_valid;
  logic [HEIGHT_W-1:0] hd_height;
  wstm_side_t          hd_side;
  logic                sc_in_rdy;
  logic                sc_valid;
  wstm_slice_t         sc_slice;
  logic                rd_in_rdy;
  logic                rd_valid;
  wstm_result_t        rd_result;

  assign s0_rdy        = ~s0_valid_q | hd_in_rdy;
  assign in_item.ready = s0_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (s0_rdy) begin
      s0_valid_q <= in_item.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_rdy) begin
      dist_q <= in_item.perp_distance;
      side_q <= side_d;
    end
  end

  // height = (screen_height << 8) / perp_distance, zero distance saturates
  wstm_height_div u_height_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s0_valid_q),
    .in_ready_o  (hd_in_rdy),
    .dist_i      (dist_q),
    .screen_h_i  (screen_h_q),
    .side_i      (side_q),
    .out_valid_o (hd_valid),
    .out_ready_i (sc_in_rdy),
    .height_o    (hd_height),
    .side_o      (hd_side)
  );

  // start/end clipping, in-slice test, texel row numerator and saturation
  wstm_slice_calc u_slice_calc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (hd_valid),
    .in_ready_o  (sc_in_rdy),
    .height_i    (hd_height),
    .screen_h_i  (screen_h_q),
    .side_i      (hd_side),
    .out_valid_o (sc_valid),
    .out_ready_i (rd_in_rdy),
    .slice_o     (sc_slice)
  );

  // tex_row = (num / height) / 2, clamped; result register at its end
  wstm_row_div u_row_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sc_valid),
    .in_ready_o  (rd_in_rdy),
    .slice_i     (sc_slice),
    .out_valid_o (rd_valid),
    .out_ready_i (out_result.ready),
    .result_o    (rd_result)
  );

  assign out_result.valid    = rd_valid;
  assign out_result.in_slice = rd_result.in_slice;
  assign out_result.use_fill = rd_result.use_fill;
  assign out_result.tex_sel  = rd_result.tex_sel;
  assign out_result.tex_col  = rd_result.tex_col;
  assign out_result.tex_row  = rd_result.tex_row;

endmodule

[hdl/wstm_checker.sv]
// Port-level assertions for the wall slice texture mapper, bound to the top.
// Depends on wstm_pkg and wall_slice_texture_mapper_top.
`timescale 1ns / 1ps

module wstm_checker import wstm_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic                 in_slice_i,
  input logic                 use_fill_i,
  input logic [CELL_W-1:0]    tex_sel_i,
  input logic [TEX_COL_W-1:0] tex_col_i,
  input logic [TEX_ROW_W-1:0] tex_row_i
);

  // No result shows while reset is held
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({in_slice_i, use_fill_i, tex_sel_i, tex_col_i, tex_row_i}))
    else $error("stalled result changed");

  // Fill cells report texture index zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_i && use_fill_i |-> tex_sel_i == '0)
    else $error("fill item with nonzero texture index");

  // Rows outside the slice have texel row zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_i && !in_slice_i |-> tex_row_i == '0)
    else $error("texel row set outside slice");

endmodule

bind wall_slice_texture_mapper_top wstm_checker u_wstm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_result.valid),
  .out_ready_i (out_result.ready),
  .in_slice_i  (out_result.in_slice),
  .use_fill_i  (out_result.use_fill),
  .tex_sel_i   (out_result.tex_sel),
  .tex_col_i   (out_result.tex_col),
  .tex_row_i   (out_result.tex_row)
);

[tb/sv/wstm_texel_checker.sv]
// Watches the pixel and texel channels and the screen height register of the
// wall slice texture mapper, predicts each texel result and compares it.
// Depends on wstm_pkg and wstm_if.
`timescale 1ns / 1ps

module wstm_texel_checker import wstm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [SCREEN_H_W-1:0] cfg_wdata_i,
  wstm_item_if                  pix_mon,
  wstm_result_if                tex_mon,
  output int unsigned           mismatch_cnt_o,
  output int unsigned           pending_o
);

  logic [SCREEN_H_W-1:0] scr_h = SCREEN_H_RESET;
  wstm_result_t          pending_texels[$];
  int unsigned           mismatches = 0;

  function automatic wstm_result_t map_pixel(
    input logic [DIST_W-1:0]     pdist,
    input logic                  hit_side,
    input logic [FRAC_W-1:0]     fx,
    input logic [FRAC_W-1:0]     fy,
    input logic                  xpos,
    input logic                  yneg,
    input logic [CELL_W-1:0]     wcell,
    input logic [ROW_W-1:0]      pix_row,
    input logic [SCREEN_H_W-1:0] screen_h
  );
    longint       h, r, height, slice_first, slice_last, num, t;
    int unsigned  frac, col;
    logic         in_rng;
    wstm_result_t res;
    h = longint'(screen_h);
    r = longint'(pix_row);
    // zero distance pins the slice height at its ceiling
    if (pdist == '0) height = longint'(18'h3FFFF);
    else             height = (h * 256) / longint'(pdist);
    slice_first = h / 2 - height / 2;
    if (slice_first < 0) slice_first = 0;
    slice_last = h / 2 + height / 2;
    if (slice_last >= h) slice_last = h - 1;
    in_rng = (r >= slice_first) && (r <= slice_last);

    frac = hit_side ? int'(fx) : int'(fy);
    col  = (frac * TEX_W) >> 8;
    if ((!hit_side && xpos) || (hit_side && yneg)) col = TEX_W - 1 - col;

    t = 0;
    if (in_rng && height > 0) begin
      num = (2 * r - h + height) * longint'(TEX_H);
      if (num > 0) begin
        t = (num / height) / 2;
        if (t > longint'(TEX_H) - 1) t = longint'(TEX_H) - 1;
      end
    end

    res.in_slice = in_rng;
    res.use_fill = (wcell == '0);
    res.tex_sel  = (wcell == '0) ? '0 : wcell - CELL_W'(1);
    res.tex_col  = TEX_COL_W'(col);
    res.tex_row  = TEX_ROW_W'(t);
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    mismatches++;
    $display("[%0t] texel check: %s got %0d, predicted %0d", $time, what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    wstm_result_t want;
    if (!rst_ni) begin
      scr_h = SCREEN_H_RESET;
      pending_texels.delete();
    end else begin
      if (cfg_we_i) scr_h = cfg_wdata_i;

      if (tex_mon.valid && tex_mon.ready) begin
        if (pending_texels.size() == 0) begin
          flag_mismatch("texel with nothing pending, tex_col", 32'(tex_mon.tex_col), 0);
        end else begin
          want = pending_texels.pop_front();
          if (tex_mon.in_slice != want.in_slice)
            flag_mismatch("in_slice", 32'(tex_mon.in_slice), 32'(want.in_slice));
          if (tex_mon.use_fill != want.use_fill)
            flag_mismatch("use_fill", 32'(tex_mon.use_fill), 32'(want.use_fill));
          if (tex_mon.tex_sel != want.tex_sel)
            flag_mismatch("tex_sel", 32'(tex_mon.tex_sel), 32'(want.tex_sel));
          if (tex_mon.tex_col != want.tex_col)
            flag_mismatch("tex_col", 32'(tex_mon.tex_col), 32'(want.tex_col));
          if (tex_mon.tex_row != want.tex_row)
            flag_mismatch("tex_row", 32'(tex_mon.tex_row), 32'(want.tex_row));
        end
      end

      if (pix_mon.valid && pix_mon.ready)
        pending_texels.push_back(map_pixel(pix_mon.perp_distance, pix_mon.side,
                                           pix_mon.hit_frac_x, pix_mon.hit_frac_y,
                                           pix_mon.ray_x_positive, pix_mon.ray_y_negative,
                                           pix_mon.wall_cell, pix_mon.row, scr_h));
    end
    mismatch_cnt_o <= mismatches;
    pending_o      <= pending_texels.size();
  end

endmodule

[tb/sv/wall_slice_texture_mapper_top_tb.sv]
// Testbench top for the wall slice texture mapper: clock, reset, pixel stimulus,
// texel back-pressure and the verdict. Depends on wstm_pkg, wstm_if,
// wstm_texel_checker and the mapper RTL.
`timescale 1ns / 1ps

module wall_slice_texture_mapper_top_tb;
  import wstm_pkg::*;

  // One pixel of one screen column: ray hit data plus the row being shaded
  typedef struct packed {
    logic [DIST_W-1:0] pdist;
    logic              hit_side;
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fy;
    logic              xpos;
    logic              yneg;
    logic [CELL_W-1:0] wcell;
    logic [ROW_W-1:0]  pix_row;
  } pixel_t;

  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 210;
  localparam int unsigned HOLD_CYCLES  = 160;  // long texel stall, fills the pipe
  localparam int unsigned DRAIN_CYCLES = 40;   // more than the pipeline latency

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [SCREEN_H_W-1:0] cfg_wdata;
  logic                  hold_kick;

  // idling knobs, changed only between phases
  int unsigned idle_pct;
  int unsigned stall_pct;
  // mirror of the screen height register, steers row selection
  logic [SCREEN_H_W-1:0] scr_h_now;

  int unsigned mismatch_cnt;
  int unsigned texels_pending;

  wstm_item_if   pix_if ();
  wstm_result_if tex_if ();

  wall_slice_texture_mapper_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_item     (pix_if),
    .out_result  (tex_if)
  );

  wstm_texel_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .pix_mon        (pix_if),
    .tex_mon        (tex_if),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (texels_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop, well beyond the slowest honest run.
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  // Texel sink. Random stalls per stall_pct; a rising hold_kick starts one long
  // hold-off that this process counts down on its own while pixels keep coming.
  initial begin
    int unsigned hold_left;
    logic        kick_prev;
    hold_left    = 0;
    kick_prev    = 1'b0;
    tex_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_kick && !kick_prev) hold_left = HOLD_CYCLES;
      kick_prev = hold_kick;
      if (hold_left != 0) begin
        tex_if.ready <= 1'b0;
        hold_left--;
      end else begin
        tex_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic pixel_t px_of(input int unsigned pdist, input bit hit_side,
                                   input int unsigned fx, input int unsigned fy,
                                   input bit xpos, input bit yneg,
                                   input int unsigned wcell, input int unsigned pix_row);
    pixel_t px;
    px.pdist    = DIST_W'(pdist);
    px.hit_side = hit_side;
    px.fx       = FRAC_W'(fx);
    px.fy       = FRAC_W'(fy);
    px.xpos     = xpos;
    px.yneg     = yneg;
    px.wcell    = CELL_W'(wcell);
    px.pix_row  = ROW_W'(pix_row);
    return px;
  endfunction

  // Hit data for one column. Distances lean toward near walls so that tall,
  // clipped slices and in-slice rows show up often; row is the first row of
  // the run, mostly on screen.
  function automatic pixel_t random_column();
    pixel_t      px;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 3)       px.pdist = '0;
    else if (pick < 23) px.pdist = DIST_W'($urandom_range(255, 1));
    else if (pick < 63) px.pdist = DIST_W'($urandom_range(4095, 256));
    else                px.pdist = DIST_W'($urandom);
    px.hit_side = 1'($urandom_range(1));
    px.fx       = FRAC_W'($urandom);
    px.fy       = FRAC_W'($urandom);
    px.xpos     = 1'($urandom_range(1));
    px.yneg     = 1'($urandom_range(1));
    px.wcell    = ($urandom_range(9) == 0) ? '0 : CELL_W'($urandom);
    if ($urandom_range(3) != 0) px.pix_row = ROW_W'($urandom_range(scr_h_now - 1));
    else                        px.pix_row = ROW_W'($urandom_range(1023));
    return px;
  endfunction

  // Offer one pixel; returns at the edge where it is taken. Called on a clock
  // edge. valid only drops when a gap is actually taken.
  task automatic offer_pixel(input pixel_t px);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      pix_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    pix_if.valid          <= 1'b1;
    pix_if.perp_distance  <= px.pdist;
    pix_if.side           <= px.hit_side;
    pix_if.hit_frac_x     <= px.fx;
    pix_if.hit_frac_y     <= px.fy;
    pix_if.ray_x_positive <= px.xpos;
    pix_if.ray_y_negative <= px.yneg;
    pix_if.wall_cell      <= px.wcell;
    pix_if.row            <= px.pix_row;
    do @(posedge clk_i); while (!pix_if.ready);
  endtask

  // Stop offering and wait for every texel in flight. The first edge lets the
  // checker count the pixel taken at the current one.
  task automatic drain_pixels();
    pix_if.valid <= 1'b0;
    @(posedge clk_i);
    while (texels_pending != 0) @(posedge clk_i);
  endtask

  // Register write, only with the pipe empty (every pixel yields a texel, so
  // an empty texel queue means an idle block).
  task automatic program_screen_height(input logic [SCREEN_H_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    scr_h_now = value;
  endtask

  initial begin : stimulus
    int unsigned               sent, run_len, k;
    pixel_t                    px;
    logic [SCREEN_H_W-1:0]     heights[PHASES];
    int unsigned               idle_tbl[4];
    int unsigned               stall_tbl[4];
    heights   = '{10'd2, 10'd1023, 10'd37, 10'd480, 10'd1000, 10'd256, 10'd3, 10'd719};
    // no idling, sender idle, receiver stalling, both
    idle_tbl  = '{0, 62, 0, 27};
    stall_tbl = '{0, 0, 62, 27};

    rst_ni                = 1'b0;
    cfg_we                = 1'b0;
    cfg_wdata             = '0;
    hold_kick             = 1'b0;
    idle_pct              = 0;
    stall_pct             = 0;
    scr_h_now             = SCREEN_H_RESET;
    pix_if.valid          = 1'b0;
    pix_if.perp_distance  = '0;
    pix_if.side           = 1'b0;
    pix_if.hit_frac_x     = '0;
    pix_if.hit_frac_y     = '0;
    pix_if.ray_x_positive = 1'b0;
    pix_if.ray_y_negative = 1'b0;
    pix_if.wall_cell      = '0;
    pix_if.row            = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed, screen height at its reset value of 480 ---
    // zero distance: saturated height, whole column; fill cell; both row ends
    offer_pixel(px_of(0, 0, 0, 0, 0, 0, 0, 0));
    offer_pixel(px_of(0, 1, 255, 255, 1, 1, 255, 479));
    offer_pixel(px_of(0, 0, 128, 255, 1, 0, 1, 1023));       // row off screen
    // farthest wall: height 1, slice is the single middle row
    offer_pixel(px_of(16'hFFFF, 0, 0, 0, 0, 0, 2, 240));
    offer_pixel(px_of(16'hFFFF, 1, 255, 0, 0, 1, 3, 239));
    offer_pixel(px_of(1, 0, 37, 200, 0, 1, 4, 240));         // huge height
    // height 240: rows 120..360, edges just outside and on them
    offer_pixel(px_of(512, 0, 64, 64, 1, 0, 10, 119));
    offer_pixel(px_of(512, 0, 64, 64, 1, 0, 10, 120));       // texel row 0
    offer_pixel(px_of(512, 1, 64, 64, 0, 0, 10, 360));       // texel row clamps
    offer_pixel(px_of(512, 1, 64, 64, 0, 1, 10, 361));
    offer_pixel(px_of(512, 0, 255, 1, 0, 0, 128, 300));
    offer_pixel(px_of(16'h8000, 1, 170, 85, 1, 1, 85, 240));
    // distance 1.0: height equals the screen, end clipped to the last row
    offer_pixel(px_of(16'h0100, 1, 85, 170, 1, 0, 170, 0));
    offer_pixel(px_of(16'h0100, 0, 1, 128, 0, 1, 255, 479));
    offer_pixel(px_of(16'h00FF, 0, 200, 63, 1, 1, 0, 512));
    drain_pixels();

    // --- directed, screen height 200: far enough walls reach zero height ---
    program_screen_height(10'd200);
    offer_pixel(px_of(16'hFFFF, 0, 0, 0, 0, 0, 1, 100));     // zero height, one row
    offer_pixel(px_of(16'hFFFF, 1, 0, 0, 0, 0, 1, 99));
    offer_pixel(px_of(16'hFFFF, 1, 0, 0, 0, 0, 1, 101));
    offer_pixel(px_of(16'hC801, 0, 9, 9, 1, 0, 7, 100));     // just past height 1
    offer_pixel(px_of(16'hC800, 0, 9, 9, 1, 0, 7, 100));     // height exactly 1
    offer_pixel(px_of(0, 1, 77, 33, 0, 1, 0, 199));
    offer_pixel(px_of(0, 0, 77, 33, 1, 0, 0, 200));
    drain_pixels();

    // --- random columns: runs of consecutive rows over one hit ---
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      program_screen_height(heights[ph]);
      idle_pct  = idle_tbl[ph % 4];
      stall_pct = stall_tbl[ph % 4];
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        px      = random_column();
        run_len = $urandom_range(12, 1);
        for (k = 0; k < run_len && sent < PHASE_ITEMS; k++) begin
          // first phase: one long texel hold-off with pixels still offered
          if (ph == 0 && sent == 16) hold_kick <= 1'b1;
          offer_pixel(px);
          px.pix_row = px.pix_row + ROW_W'(1);
          sent++;
        end
      end
      drain_pixels();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && texels_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/wstm_pkg.sv
hdl/wstm_if.sv
hdl/wstm_height_div.sv
hdl/wstm_slice_calc.sv
hdl/wstm_row_div.sv
hdl/wall_slice_texture_mapper_top.sv
hdl/wstm_checker.sv
tb/sv/wstm_texel_checker.sv
tb/sv/wall_slice_texture_mapper_top_tb.sv
